// ===== sv/thermistor_polynomial_linearizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Thermistor linearizer assertion macros
// Shared property wrappers for the linearizer core checks.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_POLYNOMIAL_LINEARIZER_CORE_DEFINES_SVH
`define THERMISTOR_POLYNOMIAL_LINEARIZER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define TPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermistor linearizer package
// Widths, coefficient ROMs, register indexes and the microcode program.
// ----------------------------------------------------------------------------
package tpl_pkg;

    // field widths
    localparam int VOLT_W     = 20;
    localparam int VOLT_MAG_W = 19;
    localparam int LIMIT_W    = 19;
    localparam int TEMP_W     = 17;
    localparam int RES_W      = 40;
    localparam int OUT_W      = 48;
    localparam int CMD_W      = 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int IN_TDATA_W = 24;

    // fixed-point datapath
    localparam int COEF_FRAC  = 20;
    localparam int OUT_SHIFT  = COEF_FRAC - 8;
    localparam int COEF_W     = 57;
    localparam int ACC_W      = 107;
    localparam int CHUNK_W    = 36;
    localparam int ACC_PAD_W  = 3 * CHUNK_W;
    localparam int PP_W       = CHUNK_W + VOLT_MAG_W;
    localparam int PROD_W     = ACC_W + VOLT_MAG_W;
    localparam int RND_W      = ACC_W + 1 - OUT_SHIFT;

    // defaults for top-level parameters
    localparam int DEF_MAX_TERMS      = 17;
    localparam int DEF_VOLT_FRAC_BITS = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TEMP = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RES  = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_LOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_HIGH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RES_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RES_HIGH   = 3'd5;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_LOW_LIMIT  = 19'd64225;
    localparam logic [LIMIT_W-1:0] RST_HIGH_LIMIT = 19'd184812;
    localparam logic [TEMP_W-1:0]  RST_TEMP_LOW   = 17'd32000;
    localparam logic [TEMP_W-1:0]  RST_TEMP_HIGH  = 17'h1D800;   // -10240
    localparam logic [RES_W-1:0]   RST_RES_LOW    = 40'd0;
    localparam logic [RES_W-1:0]   RST_RES_HIGH   = 40'd256000000;

    // coefficient magnitude: integer part plus a nano fraction, 20 fraction bits
    function automatic logic [COEF_W-1:0] coef_mag(input longint unsigned ip,
                                                   input longint unsigned nano);
        longint unsigned f;
        longint unsigned m;
        f = ((nano << COEF_FRAC) + 64'd500000000) / 64'd1000000000;
        m = (ip << COEF_FRAC) + f;
        return m[COEF_W-1:0];
    endfunction

    localparam int TEMP_TERMS = 8;
    localparam int RES_TERMS  = 17;
    localparam int TEMP_IDX_W = $clog2(TEMP_TERMS);

    localparam logic [COEF_W-1:0] TEMP_MAG [TEMP_TERMS] = '{
        coef_mag(64'd5434,  64'd232117314), coef_mag(64'd20169, 64'd466246021),
        coef_mag(64'd32463, 64'd933111048), coef_mag(64'd28938, 64'd226799701),
        coef_mag(64'd15353, 64'd409347028), coef_mag(64'd4841,  64'd37714595),
        coef_mag(64'd839,   64'd510375889), coef_mag(64'd61,    64'd781542504)
    };
    localparam logic [TEMP_TERMS-1:0] TEMP_NEG = 8'b1010_1010;

    localparam logic [COEF_W-1:0] RES_MAG [RES_TERMS] = '{
        coef_mag(64'd2632885515,  64'd135468006), coef_mag(64'd17311600570, 64'd389953613),
        coef_mag(64'd47184509415, 64'd495796204), coef_mag(64'd63846048453, 64'd618972778),
        coef_mag(64'd30425587321, 64'd680206299), coef_mag(64'd32478530833, 64'd112487793),
        coef_mag(64'd55239679692, 64'd875663757), coef_mag(64'd12613996299, 64'd498186111),
        coef_mag(64'd45302555776, 64'd647583008), coef_mag(64'd65979595200, 64'd796844482),
        coef_mag(64'd49283512285, 64'd732422),    coef_mag(64'd23980911162, 64'd897621155),
        coef_mag(64'd8027982169,  64'd407816887), coef_mag(64'd1848415946,  64'd544223785),
        coef_mag(64'd281176298,   64'd883506835), coef_mag(64'd25534498,    64'd307311792),
        coef_mag(64'd1050791,     64'd210161465)
    };
    localparam logic [RES_TERMS-1:0] RES_NEG = 17'b0_1010_1010_0100_1010;

    // microcode
    localparam int UPC_W    = 3;
    localparam int UC_DEPTH = 8;

    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,   // take a word from the input
        OP_INIT  = 3'd1,   // load top coefficient
        OP_MUL0  = 3'd2,   // partial product, low chunk
        OP_MUL1  = 3'd3,
        OP_MUL2  = 3'd4,   // last chunk, round and write accumulator
        OP_ADD   = 3'd5,   // add next coefficient
        OP_ROUND = 3'd6,   // scale to output units
        OP_CLAMP = 3'd7    // output a configured bound
    } t_uop;

    typedef enum logic [1:0] {
        CD_NEXT  = 2'd0,
        CD_JUMP  = 2'd1,
        CD_RANGE = 2'd2,   // jump when the voltage is outside the limits
        CD_MORE  = 2'd3    // jump while coefficients remain
    } t_ucond;

    typedef struct packed {
        t_uop               op;
        t_ucond             cond;
        logic [UPC_W-1:0]   target;
    } t_uword;

    localparam logic [UPC_W-1:0] UA_WAIT  = 3'd0;
    localparam logic [UPC_W-1:0] UA_INIT  = 3'd1;
    localparam logic [UPC_W-1:0] UA_MUL0  = 3'd2;
    localparam logic [UPC_W-1:0] UA_MUL1  = 3'd3;
    localparam logic [UPC_W-1:0] UA_MUL2  = 3'd4;
    localparam logic [UPC_W-1:0] UA_ADD   = 3'd5;
    localparam logic [UPC_W-1:0] UA_ROUND = 3'd6;
    localparam logic [UPC_W-1:0] UA_CLAMP = 3'd7;

    localparam t_uword UCODE [UC_DEPTH] = '{
        '{op: OP_WAIT,  cond: CD_NEXT,  target: UA_WAIT},
        '{op: OP_INIT,  cond: CD_RANGE, target: UA_CLAMP},
        '{op: OP_MUL0,  cond: CD_NEXT,  target: UA_WAIT},
        '{op: OP_MUL1,  cond: CD_NEXT,  target: UA_WAIT},
        '{op: OP_MUL2,  cond: CD_NEXT,  target: UA_WAIT},
        '{op: OP_ADD,   cond: CD_MORE,  target: UA_MUL0},
        '{op: OP_ROUND, cond: CD_JUMP,  target: UA_WAIT},
        '{op: OP_CLAMP, cond: CD_JUMP,  target: UA_WAIT}
    };

endpackage

// ===== sv/thermistor_polynomial_linearizer_core.sv =====
// ----------------------------------------------------------------------------
// Thermistor polynomial linearizer core
// Voltage sample to temperature or resistance through a Horner evaluation
// driven by a small microcode program over a shared 36x19 multiplier.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                  | handshake
//  s_axis    | in  | tuser: command; tdata: voltage [19:0]    | tvalid/tready
//  m_axis    | out | tdata: value [47:0]                      | tvalid/tready
//  i_cfg     | in  | i_cfg_addr index, i_cfg_wdata            | i_cfg_we
//
//  A polynomial word runs init, one Horner step per further coefficient,
//  then round; a clamped voltage goes from init to clamp. Each Horner
//  step takes three multiplier passes and one coefficient add.
//  Reset loads register defaults and returns the sequencer to its wait step.
//  A result waits in the output register; the next word is taken meanwhile
//  and the sequencer holds only for input or when a new result finds that register full.
`include "thermistor_polynomial_linearizer_core_defines.svh"

module thermistor_polynomial_linearizer_core #(
    parameter int MAX_TERMS      = tpl_pkg::DEF_MAX_TERMS,
    parameter int VOLT_FRAC_BITS = tpl_pkg::DEF_VOLT_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tpl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [19:0] voltage
    input  logic [tpl_pkg::CMD_W-1:0]         s_axis_tuser,   // [0] command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tpl_pkg::OUT_W-1:0]         m_axis_tdata,   // [47:0] value
    input  logic                              i_cfg_we,
    input  logic [tpl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tpl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import tpl_pkg::*;

    localparam int N_TEMP = (TEMP_TERMS < MAX_TERMS) ? TEMP_TERMS : MAX_TERMS;
    localparam int N_RES  = (RES_TERMS < MAX_TERMS) ? RES_TERMS : MAX_TERMS;
    localparam int K_W    = $clog2(N_RES);
    localparam int LOW_WORD_W = 64;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [PROD_W-1:0] MUL_HALF = PROD_W'(1) << (VOLT_FRAC_BITS - 1);
    localparam logic [ACC_W:0]    OUT_HALF = (ACC_W + 1)'(1) << (OUT_SHIFT - 1);
    localparam logic [RND_W-1:0]  POS_MAX  = (RND_W'(1) << (OUT_W - 1)) - RND_W'(1);
    localparam logic [RND_W-1:0]  NEG_MAX  = RND_W'(1) << (OUT_W - 1);

    // configuration
    logic [LIMIT_W-1:0] r_low_limit, r_high_limit;
    logic [TEMP_W-1:0]  r_temp_low, r_temp_high;
    logic [RES_W-1:0]   r_res_low, r_res_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= RST_LOW_LIMIT;
            r_high_limit <= RST_HIGH_LIMIT;
            r_temp_low   <= RST_TEMP_LOW;
            r_temp_high  <= RST_TEMP_HIGH;
            r_res_low    <= RST_RES_LOW;
            r_res_high   <= RST_RES_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_TEMP_LOW:   r_temp_low   <= i_cfg_wdata[TEMP_W-1:0];
                CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_wdata[TEMP_W-1:0];
                CFG_RES_LOW:    r_res_low    <= i_cfg_wdata[RES_W-1:0];
                CFG_RES_HIGH:   r_res_high   <= i_cfg_wdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    logic [UPC_W-1:0]  r_upc, n_upc;
    logic [CMD_W-1:0]  r_cmd;
    logic [VOLT_W-1:0] r_volt;
    logic [K_W-1:0]    r_k, n_k;
    logic              r_acc_neg, n_acc_neg;
    logic [ACC_W-1:0]  r_acc_mag, n_acc_mag;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_value, n_out_value;

    t_uword w_uw;
    logic   w_below, w_above, w_range, w_out_free, w_hold, w_jump;
    logic   w_accept;

    assign w_uw       = UCODE[r_upc];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_below = $signed(r_volt) < $signed({1'b0, r_low_limit});
    assign w_above = $signed(r_volt) > $signed({1'b0, r_high_limit});
    assign w_range = w_below || w_above;

    // coefficient fetch
    logic [K_W-1:0]    w_idx;
    logic [COEF_W-1:0] w_cmag;
    logic              w_cneg;

    always_comb begin
        if (w_uw.op == OP_INIT) begin
            w_idx = (r_cmd == CMD_RES) ? K_W'(N_RES - 1) : K_W'(N_TEMP - 1);
        end else begin
            w_idx = r_k - 1'b1;
        end
        if (r_cmd == CMD_RES) begin
            w_cmag = RES_MAG[w_idx];
            w_cneg = RES_NEG[w_idx];
        end else begin
            w_cmag = TEMP_MAG[w_idx[TEMP_IDX_W-1:0]];
            w_cneg = TEMP_NEG[w_idx[TEMP_IDX_W-1:0]];
        end
    end

    // multiplier: one accumulator chunk by the voltage per pass
    logic [ACC_PAD_W-1:0] w_acc_pad;
    logic [CHUNK_W-1:0]   w_chunk;
    logic [PP_W-1:0]      w_pp;
    logic [PROD_W-1:0]    w_total, w_shr;
    logic [ACC_W-1:0]     w_mul_mag;

    assign w_acc_pad = {{(ACC_PAD_W - ACC_W){1'b0}}, r_acc_mag};

    always_comb begin
        case (w_uw.op)
            OP_MUL0: w_chunk = w_acc_pad[CHUNK_W-1:0];
            OP_MUL1: w_chunk = w_acc_pad[2*CHUNK_W-1:CHUNK_W];
            default: w_chunk = w_acc_pad[3*CHUNK_W-1:2*CHUNK_W];
        endcase
    end

    assign w_pp      = w_chunk * r_volt[VOLT_MAG_W-1:0];
    assign w_total   = r_prod + (PROD_W'(w_pp) << (2 * CHUNK_W));
    assign w_shr     = w_total >> VOLT_FRAC_BITS;
    assign w_mul_mag = (w_shr > PROD_W'(ACC_MAX)) ? ACC_MAX : w_shr[ACC_W-1:0];

    // sign-magnitude coefficient add
    logic [ACC_W:0]          w_sum, w_diff, w_rdiff;
    logic [ACC_W-1:0]        w_add_mag;
    logic                    w_add_neg, w_same;
    logic                    w_acc_hi_nz;
    logic [LOW_WORD_W-1:0]   w_lo_diff;

    assign w_same      = (r_acc_neg == w_cneg) || (r_acc_mag == '0);
    assign w_sum       = {1'b0, r_acc_mag} + (ACC_W + 1)'(w_cmag);
    assign w_acc_hi_nz = (r_acc_mag[ACC_W-1:LOW_WORD_W] != '0);
    assign w_lo_diff   = r_acc_mag[LOW_WORD_W-1:0] - LOW_WORD_W'(w_cmag);
    // with upper bits set, the subtract is done in the low 64 bits only; a borrow out of them is dropped
    assign w_diff  = w_acc_hi_nz ? {1'b0, r_acc_mag[ACC_W-1:LOW_WORD_W], w_lo_diff}
                                 : {1'b0, r_acc_mag} - (ACC_W + 1)'(w_cmag);
    assign w_rdiff = (ACC_W + 1)'(w_cmag) - {1'b0, r_acc_mag};

    always_comb begin
        if (w_same) begin
            w_add_mag = w_sum[ACC_W] ? ACC_MAX : w_sum[ACC_W-1:0];
            w_add_neg = w_cneg;
        end else if (!w_diff[ACC_W]) begin
            w_add_mag = w_diff[ACC_W-1:0];
            w_add_neg = r_acc_neg;
        end else begin
            w_add_mag = w_rdiff[ACC_W-1:0];
            w_add_neg = w_cneg;
        end
    end

    // output scaling and saturation
    logic [ACC_W:0]   w_rnd_sum;
    logic [RND_W-1:0] w_rnd;
    logic [OUT_W-1:0] w_poly_out, w_clamp_out;

    assign w_rnd_sum = {1'b0, r_acc_mag} + OUT_HALF;
    assign w_rnd     = w_rnd_sum[ACC_W:OUT_SHIFT];

    always_comb begin
        if (w_rnd == '0) begin
            w_poly_out = '0;
        end else if (r_acc_neg) begin
            if (r_cmd == CMD_RES) begin
                w_poly_out = '0;   // negative resistance reads as zero
            end else if (w_rnd > NEG_MAX) begin
                w_poly_out = OUT_W'(0) - NEG_MAX[OUT_W-1:0];
            end else begin
                w_poly_out = OUT_W'(0) - w_rnd[OUT_W-1:0];
            end
        end else begin
            w_poly_out = (w_rnd > POS_MAX) ? POS_MAX[OUT_W-1:0] : w_rnd[OUT_W-1:0];
        end

        if (r_cmd == CMD_RES) begin
            w_clamp_out = w_below ? {{(OUT_W - RES_W){1'b0}}, r_res_low}
                                  : {{(OUT_W - RES_W){1'b0}}, r_res_high};
        end else begin
            w_clamp_out = w_below ? {{(OUT_W - TEMP_W){r_temp_low[TEMP_W-1]}}, r_temp_low}
                                  : {{(OUT_W - TEMP_W){r_temp_high[TEMP_W-1]}}, r_temp_high};
        end
    end

    // next-address logic
    always_comb begin
        case (w_uw.cond)
            CD_NEXT:  w_jump = 1'b0;
            CD_JUMP:  w_jump = 1'b1;
            CD_RANGE: w_jump = w_range;
            CD_MORE:  w_jump = (r_k != K_W'(1));
            default:  w_jump = 1'b0;
        endcase
        w_hold = ((w_uw.op == OP_WAIT) && !s_axis_tvalid) ||
                 (((w_uw.op == OP_ROUND) || (w_uw.op == OP_CLAMP)) && !w_out_free);
        if (w_hold) begin
            n_upc = r_upc;
        end else if (w_jump) begin
            n_upc = w_uw.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    // datapath control
    always_comb begin
        n_k         = r_k;
        n_acc_neg   = r_acc_neg;
        n_acc_mag   = r_acc_mag;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_value = r_out_value;
        case (w_uw.op)
            OP_INIT: begin
                n_k       = w_idx;
                n_acc_mag = ACC_W'(w_cmag);
                n_acc_neg = w_cneg && (w_cmag != '0);
            end
            OP_MUL0: n_prod = MUL_HALF + PROD_W'(w_pp);
            OP_MUL1: n_prod = r_prod + (PROD_W'(w_pp) << CHUNK_W);
            OP_MUL2: begin
                n_acc_mag = w_mul_mag;
                n_acc_neg = r_acc_neg && (w_mul_mag != '0);
            end
            OP_ADD: begin
                n_k       = r_k - 1'b1;
                n_acc_mag = w_add_mag;
                n_acc_neg = w_add_neg && (w_add_mag != '0);
            end
            OP_ROUND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_poly_out;
                end
            end
            OP_CLAMP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_clamp_out;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= s_axis_tuser;
            r_volt <= s_axis_tdata[VOLT_W-1:0];
        end
        r_k         <= n_k;
        r_acc_neg   <= n_acc_neg;
        r_acc_mag   <= n_acc_mag;
        r_prod      <= n_prod;
        r_out_value <= n_out_value;
    end

    assign s_axis_tready = i_rst_n && (w_uw.op == OP_WAIT);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;

    // checks
    `TPL_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_upc == UA_INIT, "accept did not start evaluation")
    `TPL_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, ((r_upc == UA_ROUND) || (r_upc == UA_CLAMP)) && w_out_free, m_axis_tvalid && (r_upc == UA_WAIT), "result not loaded")
    `TPL_ASSERT_IMP(a_no_neg_zero, i_clk, i_rst_n, r_acc_neg && (r_upc != UA_WAIT) && (r_upc != UA_INIT), r_acc_mag != '0, "negative zero in accumulator")
    `TPL_ASSERT_IMP(a_terms_left, i_clk, i_rst_n, (r_upc == UA_MUL0) || (r_upc == UA_ADD), r_k != '0, "coefficient counter underflow")

endmodule
